// ===== hdl/sci_pkg.sv =====
// Shared widths and stage-to-stage types for the segment/circle intersect pipeline.
package sci_pkg;
	localparam int CoordW = 16;
	localparam int RadW   = 15;
	localparam int DiffW  = 17;   // coordinate difference
	localparam int SqW    = 35;   // sum of two 17x17 products, signed
	localparam int ProdW  = 70;   // product of two squared terms

	typedef struct packed {
		logic signed [SqW-1:0] i;
		logic signed [SqW-1:0] h;
		logic signed [SqW+1:0] k;
	} sci_quad_t;

	typedef struct packed {
		logic              ipos;
		logic              kle0;
		logic              t1;
		logic              t2;
	} sci_flags_t;
endpackage

// ===== hdl/segment_circle_intersect_unit.sv =====
// Top level of the segment/circle intersect pipeline.
// Segment/circle hit test: one segment and one circle per beat, one hit bit per
// beat, exact integer decision. Four register stages (differences, dot
// products, square compare of the discriminant, final hit); throughput is
// one beat per cycle unless the output stalls. A stall on the output freezes
// the whole pipeline; with an empty output stage the input keeps flowing.
module segment_circle_intersect_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic signed [sci_pkg::CoordW-1:0] seg_x0,
	input  logic signed [sci_pkg::CoordW-1:0] seg_y0,
	input  logic signed [sci_pkg::CoordW-1:0] seg_x1,
	input  logic signed [sci_pkg::CoordW-1:0] seg_y1,
	input  logic signed [sci_pkg::CoordW-1:0] center_x,
	input  logic signed [sci_pkg::CoordW-1:0] center_y,
	input  logic        [sci_pkg::RadW-1:0]   radius,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic                              hit
);
	logic               adv, v_s2;
	sci_pkg::sci_quad_t quad_s2;

	// advance whenever the last stage is empty or being taken
	assign adv      = !(out_valid && out_stall);
	assign in_stall = !adv;

	sci_front u_front (
		.clk, .arst_n, .adv, .in_v(in_valid),
		.seg_x0, .seg_y0, .seg_x1, .seg_y1, .center_x, .center_y, .radius,
		.v_s2, .quad_s2
	);

	sci_decide u_decide (
		.clk, .arst_n, .adv, .v_s2, .quad_s2,
		.v_s4(out_valid), .hit_s4(hit)
	);
endmodule

// ===== hdl/sci_front.sv =====
// Front stages: differences, then the dot products that form i, h and k.
module sci_front (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              adv,
	input  logic                              in_v,
	input  logic signed [sci_pkg::CoordW-1:0] seg_x0,
	input  logic signed [sci_pkg::CoordW-1:0] seg_y0,
	input  logic signed [sci_pkg::CoordW-1:0] seg_x1,
	input  logic signed [sci_pkg::CoordW-1:0] seg_y1,
	input  logic signed [sci_pkg::CoordW-1:0] center_x,
	input  logic signed [sci_pkg::CoordW-1:0] center_y,
	input  logic        [sci_pkg::RadW-1:0]   radius,
	output logic                              v_s2,
	output sci_pkg::sci_quad_t                quad_s2
);
	logic                              v_s1;
	logic signed [sci_pkg::DiffW-1:0]  dx_s1, dy_s1, fx_s1, fy_s1;
	logic        [sci_pkg::RadW-1:0]   r_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_v;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dx_s1 <= 17'(seg_x1) - 17'(seg_x0);
			dy_s1 <= 17'(seg_y1) - 17'(seg_y0);
			fx_s1 <= 17'(seg_x0) - 17'(center_x);
			fy_s1 <= 17'(seg_y0) - 17'(center_y);
			r_s1  <= radius;
			quad_s2.i <= 35'(dx_s1 * dx_s1) + 35'(dy_s1 * dy_s1);
			quad_s2.h <= 35'(fx_s1 * dx_s1) + 35'(fy_s1 * dy_s1);
			quad_s2.k <= 37'(fx_s1 * fx_s1) + 37'(fy_s1 * fy_s1)
				- 37'(r_s1) * 37'(r_s1);
		end
	end
endmodule

// ===== hdl/sci_decide.sv =====
// Back stages: discriminant by square compare, root range tests, hit.
module sci_decide (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               adv,
	input  logic               v_s2,
	input  sci_pkg::sci_quad_t quad_s2,
	output logic               v_s4,
	output logic               hit_s4
);
	logic                             v_s3;
	sci_pkg::sci_flags_t              fl_s3;
	logic [sci_pkg::ProdW-1:0]        hh_s3, ik_s3;
	logic signed [sci_pkg::SqW+2:0]   hi, q;
	logic [sci_pkg::SqW-1:0]          ah;

	always_comb begin
		hi = 38'(quad_s2.h) + 38'(quad_s2.i);
		q  = hi + 38'(quad_s2.h) + 38'(quad_s2.k);
		ah = quad_s2.h[sci_pkg::SqW-1] ? 35'(-quad_s2.h) : quad_s2.h;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			fl_s3.ipos      <= quad_s2.i > 0;
			fl_s3.kle0      <= quad_s2.k <= 0;
			fl_s3.t1 <= (quad_s2.h <= 0) && (quad_s2.k >= 0) && ((hi >= 0) || (q <= 0));
			fl_s3.t2 <= ((quad_s2.h <= 0) || (quad_s2.k <= 0)) && (hi >= 0) && (q >= 0);
			hh_s3 <= 70'(ah) * 70'(ah);
			// k is positive whenever this product matters
			ik_s3 <= 70'(quad_s2.i[sci_pkg::SqW-1:0]) * 70'(quad_s2.k[sci_pkg::SqW:0]);
			hit_s4 <= fl_s3.ipos && (fl_s3.kle0 || (hh_s3 >= ik_s3))
				&& (fl_s3.t1 || fl_s3.t2);
		end
	end
endmodule

// ===== hdl/sci_checker.sv =====
// Port-level checks for the segment/circle intersect unit.
module sci_checker (
	input logic clk,
	input logic arst_n,
	input logic in_stall,
	input logic out_valid,
	input logic out_stall,
	input logic hit
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(hit)) else $error("output beat dropped");
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall) else $error("needless input stall");
	a_free: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> !in_stall) else $error("stall with empty output");
endmodule

bind segment_circle_intersect_unit sci_checker u_sci_checker (
	.clk, .arst_n, .in_stall, .out_valid, .out_stall, .hit
);

// ===== test/tb_segment_circle_intersect_unit.sv =====
// Self-checking testbench for the segment/circle intersect pipeline.
module tb_segment_circle_intersect_unit;
	timeunit 1ns;
	timeprecision 1ps;

	typedef logic signed [sci_pkg::CoordW-1:0] coord_t;
	typedef logic [sci_pkg::RadW-1:0] rad_t;

	typedef enum int {CMP_OK, CMP_WRONG, CMP_UNEXPECTED} cmp_e;
	typedef enum int {PH_FREE, PH_SEND_IDLE, PH_RECV_STALL, PH_BOTH} phase_e;

	// Exact hit decision: discriminant by square compare, roots by signs.
	function automatic bit segment_meets_circle(coord_t x0, coord_t y0, coord_t x1, coord_t y1,
			coord_t cx, coord_t cy, rad_t r);
		longint dx, dy, fx, fy, i, h, k, q;
		logic [127:0] ah, sq_h, prod_ik;
		bit has_roots, t1, t2;
		dx = longint'(x1) - longint'(x0);
		dy = longint'(y1) - longint'(y0);
		fx = longint'(x0) - longint'(cx);
		fy = longint'(y0) - longint'(cy);
		i = dx * dx + dy * dy;
		h = fx * dx + fy * dy;
		k = fx * fx + fy * fy - longint'(r) * longint'(r);
		q = i + 2 * h + k;
		if (i <= 0)
			return 1'b0;
		if (k <= 0) begin
			has_roots = 1'b1;
		end else begin
			ah = (h < 0) ? 128'(-h) : 128'(h);
			sq_h = ah * ah;
			prod_ik = 128'(i) * 128'(k);
			has_roots = sq_h >= prod_ik;
		end
		if (!has_roots)
			return 1'b0;
		t1 = (h <= 0) && (k >= 0) && ((h + i >= 0) || (q <= 0));
		t2 = ((h <= 0) || (k <= 0)) && (h + i >= 0) && (q >= 0);
		return t1 || t2;
	endfunction

	class hit_scoreboard;
		bit hits_due[$];

		function void note_segment(coord_t x0, coord_t y0, coord_t x1, coord_t y1,
				coord_t cx, coord_t cy, rad_t r);
			hits_due.push_back(segment_meets_circle(x0, y0, x1, y1, cx, cy, r));
		endfunction

		function cmp_e check_hit(bit got, output bit want);
			want = 1'b0;
			if (hits_due.size() == 0)
				return CMP_UNEXPECTED;
			want = hits_due.pop_front();
			return (got == want) ? CMP_OK : CMP_WRONG;
		endfunction

		function int pending();
			return hits_due.size();
		endfunction
	endclass

	logic   clk = 1'b0;
	logic   arst_n = 1'b0;
	logic   in_valid = 1'b0;
	logic   in_stall;
	coord_t seg_x0 = '0, seg_y0 = '0, seg_x1 = '0, seg_y1 = '0;
	coord_t center_x = '0, center_y = '0;
	rad_t   radius = '0;
	logic   out_valid;
	logic   out_stall = 1'b0;
	logic   hit;

	hit_scoreboard sb = new();
	int     mismatches = 0;
	phase_e phase = PH_FREE;

	segment_circle_intersect_unit u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.seg_x0   (seg_x0),
		.seg_y0   (seg_y0),
		.seg_x1   (seg_x1),
		.seg_y1   (seg_y1),
		.center_x (center_x),
		.center_y (center_y),
		.radius   (radius),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.hit      (hit)
	);

	always #5 clk = ~clk;

	task automatic report(string what);
		$display("[%0t] mismatch: %s", $realtime, what);
		mismatches++;
	endtask

	// Offer one beat and hold it until the block takes it. The stall seen right
	// after the edge is the pre-edge value, so this is exactly the acceptance test.
	task automatic send_segment(coord_t x0, coord_t y0, coord_t x1, coord_t y1,
			coord_t cx, coord_t cy, rad_t r);
		seg_x0   <= x0;
		seg_y0   <= y0;
		seg_x1   <= x1;
		seg_y1   <= y1;
		center_x <= cx;
		center_y <= cy;
		radius   <= r;
		in_valid <= 1'b1;
		do
			@(posedge clk);
		while (in_stall);
		sb.note_segment(x0, y0, x1, y1, cx, cy, r);
	endtask

	// Drop valid for a random number of cycles when the phase asks the sender to idle.
	task automatic sender_gap();
		int pct;
		pct = (phase == PH_BOTH) ? 18 : 46;
		if ((phase == PH_SEND_IDLE || phase == PH_BOTH) && $urandom_range(99) < pct) begin
			in_valid <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(99) < pct);
		end
	endtask

	// Random item, mostly shaped so that the segment lands near the circle.
	task automatic send_random();
		coord_t cx, cy;
		int span;
		cx = coord_t'($urandom);
		cy = coord_t'($urandom);
		case ($urandom_range(7))
			0, 1: begin
				// full range noise: every bit of every field
				send_segment(coord_t'($urandom), coord_t'($urandom), coord_t'($urandom),
					coord_t'($urandom), cx, cy, rad_t'($urandom));
			end
			2: begin
				// zero-length segment
				seg_pt: begin
					coord_t px, py;
					px = coord_t'($urandom);
					py = coord_t'($urandom);
					send_segment(px, py, px, py, cx, cy, rad_t'($urandom));
				end
			end
			default: begin
				// segment endpoints around the center, radius of similar scale
				span = 1 << $urandom_range(2, 14);
				send_segment(
					coord_t'(cx + $signed($urandom_range(2 * span)) - span),
					coord_t'(cy + $signed($urandom_range(2 * span)) - span),
					coord_t'(cx + $signed($urandom_range(2 * span)) - span),
					coord_t'(cy + $signed($urandom_range(2 * span)) - span),
					cx, cy, rad_t'($urandom_range(span)));
			end
		endcase
	endtask

	// Receiver: random stall by phase, plus one long hold-off that fills the pipe.
	int recv_cycles = 0;
	int hold_left = 0;
	always @(posedge clk) begin
		if (arst_n) begin
			recv_cycles++;
			if (recv_cycles == 300)
				hold_left = 90;
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else if (phase == PH_RECV_STALL) begin
				out_stall <= ($urandom_range(99) < 46);
			end else if (phase == PH_BOTH) begin
				out_stall <= ($urandom_range(99) < 18);
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// Check every result beat against the oldest expected hit.
	always @(posedge clk) begin
		bit want;
		cmp_e verdict;
		if (arst_n && out_valid && !out_stall) begin
			verdict = sb.check_hit(hit, want);
			if (verdict == CMP_UNEXPECTED)
				report($sformatf("result beat hit=%0b with nothing expected", hit));
			else if (verdict == CMP_WRONG)
				report($sformatf("hit=%0b, expected %0b", hit, want));
		end
	end

	// Watchdog: far beyond the slowest legal run.
	initial begin
		#3ms;
		$display("FAILURE");
		$finish;
	end

	initial begin
		int drain;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: extremes, zero length, inside, tangent, endpoint on circle, crossing.
		send_segment(-16'sd32768, -16'sd32768, 16'sd32767, 16'sd32767, 16'sd0, 16'sd0, 15'd0);
		send_segment(16'sd32767, -16'sd32768, -16'sd32768, 16'sd32767,
			-16'sd32768, -16'sd32768, 15'd32767);
		send_segment(-16'sd32768, -16'sd32768, -16'sd32768, 16'sd32767,
			16'sd32767, 16'sd32767, 15'd32767);
		send_segment(16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767,
			16'sd32767, 16'sd32767, 15'd32767);
		send_segment(16'sd10, 16'sd10, 16'sd10, 16'sd10, 16'sd10, 16'sd10, 15'd5);
		send_segment(-16'sd2, 16'sd0, 16'sd2, 16'sd0, 16'sd0, 16'sd0, 15'd100);
		send_segment(-16'sd5, 16'sd3, 16'sd5, 16'sd3, 16'sd0, 16'sd0, 15'd3);
		send_segment(-16'sd5, 16'sd4, 16'sd5, 16'sd4, 16'sd0, 16'sd0, 15'd3);
		send_segment(16'sd3, 16'sd0, 16'sd9, 16'sd0, 16'sd0, 16'sd0, 15'd3);
		send_segment(16'sd9, 16'sd0, 16'sd3, 16'sd0, 16'sd0, 16'sd0, 15'd3);
		send_segment(-16'sd20, 16'sd0, 16'sd20, 16'sd0, 16'sd0, 16'sd0, 15'd7);
		send_segment(16'sd0, 16'sd0, 16'sd20, 16'sd0, 16'sd0, 16'sd0, 15'd7);
		send_segment(16'sd20, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 15'd7);
		send_segment(16'sd10, 16'sd0, 16'sd20, 16'sd0, 16'sd0, 16'sd0, 15'd7);
		send_segment(-16'sd20, 16'sd0, -16'sd10, 16'sd0, 16'sd0, 16'sd0, 15'd7);
		send_segment(16'sd0, 16'sd0, 16'sd0, 16'sd1, 16'sd0, 16'sd0, 15'd0);
		send_segment(-16'sd32768, 16'sd0, 16'sd32767, 16'sd0,
			16'sd0, 16'sd32767, 15'd32767);
		send_segment(-16'sd32768, -16'sd32768, 16'sd32767, -16'sd32768,
			16'sd0, 16'sd0, 15'd32767);
		send_segment(16'sd32767, 16'sd32767, -16'sd32768, -16'sd32768,
			16'sd32767, -16'sd32768, 15'd1);

		// Random phases: free running, sender idles, receiver stalls, both.
		for (int p = PH_FREE; p <= PH_BOTH; p++) begin
			phase = phase_e'(p);
			repeat (335) begin
				sender_gap();
				send_random();
			end
		end
		in_valid <= 1'b0;

		while (sb.pending() != 0)
			@(posedge clk);
		drain = 0;
		while (drain < 10) begin
			@(posedge clk);
			drain++;
		end

		if (mismatches == 0 && sb.pending() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end
endmodule
